/* rtl/glc_pkg.sv */
// glc_pkg: shared types and constants for the gemtext line classifier.
// Holds the configuration struct, the queue word between the front and back
// parts, the result word and the line type / role / register codes.
`default_nettype none

package glc_pkg;

    // line type codes
    localparam logic [3:0] LT_TEXT        = 4'd0;
    localparam logic [3:0] LT_H1          = 4'd1;
    localparam logic [3:0] LT_H3          = 4'd3;
    localparam logic [3:0] LT_ITEM        = 4'd4;
    localparam logic [3:0] LT_QUOTE       = 4'd5;
    localparam logic [3:0] LT_LINK        = 4'd6;
    localparam logic [3:0] LT_PRE_START   = 4'd7;
    localparam logic [3:0] LT_PRE_CONTENT = 4'd8;
    localparam logic [3:0] LT_PRE_END     = 4'd9;

    // byte roles
    localparam logic [1:0] ROLE_BODY  = 2'd0;
    localparam logic [1:0] ROLE_URL   = 2'd1;
    localparam logic [1:0] ROLE_LABEL = 2'd2;

    // marker bytes
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_TICK  = 8'h60;

    // configuration register indexes
    localparam logic [1:0] REG_HIDE_PRE_FENCE   = 2'd0;
    localparam logic [1:0] REG_HIDE_PRE_CLOSING = 2'd1;
    localparam logic [1:0] REG_HIDE_PRE_CONTENT = 2'd2;
    localparam logic [1:0] REG_STYLING_OFF      = 2'd3;

    typedef struct packed {
        logic hide_pre_fence;
        logic hide_pre_closing;
        logic hide_pre_content;
        logic styling_off;
    } cfg_t;

    // one queue word: everything one input item yields.
    // mask bits in output order: [0] first held byte, [1] second held byte,
    // [2] content byte, [3] line record
    typedef struct packed {
        logic [3:0] mask;
        logic [7:0] rel_char;
        logic [7:0] ch;
        logic [1:0] role;
        logic [3:0] line_class;
        logic       hidden;
        logic       label_from_url;
    } pkt_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_out_char;
        logic [1:0] char_role;
        logic       line_record;
        logic [3:0] line_class;
        logic       hidden;
        logic       label_from_url;
        logic       last_result;
    } res_t;

endpackage

`default_nettype wire

/* rtl/glc_front.sv */
// glc_front: per-byte line classifier; one item a cycle in while take is high,
// at most one queue word out per item. Depends on glc_pkg.
`default_nettype none

module glc_front
    import glc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] char_value,
    input  wire logic       has_char,
    input  wire logic       last_in_line,
    input  wire logic       take,
    input  wire cfg_t       cfg,
    output pkt_t            pkt,
    output logic            pkt_valid
);

    typedef enum logic [11:0] {
        PH_START  = 12'b0000_0000_0001,
        PH_STAR   = 12'b0000_0000_0010,
        PH_EQ     = 12'b0000_0000_0100,
        PH_TICK   = 12'b0000_0000_1000,
        PH_HASH   = 12'b0000_0001_0000,
        PH_SKIPWS = 12'b0000_0010_0000,
        PH_BODY   = 12'b0000_0100_0000,
        PH_LINKWS = 12'b0000_1000_0000,
        PH_URL    = 12'b0001_0000_0000,
        PH_GAP    = 12'b0010_0000_0000,
        PH_LABEL  = 12'b0100_0000_0000,
        PH_DROP   = 12'b1000_0000_0000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       in_pre_reg, in_pre_next;
    logic [1:0] pend_reg, pend_next;
    logic [3:0] kind_reg, kind_next;
    logic       label_reg, label_next;

    function automatic logic [7:0] marker(input phase_t p);
        logic [7:0] m;
        m = CH_TICK;
        if (p == PH_STAR)
            m = CH_STAR;
        else if (p == PH_EQ)
            m = CH_EQ;
        return m;
    endfunction

    logic       ws;
    logic       go_body;
    logic [1:0] rel_n;
    logic [7:0] rel_ch;
    logic       byte_en;
    logic [1:0] byte_role;
    logic       rec_en;
    logic [3:0] rec_type;
    logic       hid;
    logic       lfu;

    assign ws = (char_value == CH_SPACE) || (char_value >= 8'd9 && char_value <= 8'd13);

    always_comb
    begin
        phase_next  = phase_reg;
        in_pre_next = in_pre_reg;
        pend_next   = pend_reg;
        kind_next   = kind_reg;
        label_next  = label_reg;
        go_body     = 1'b0;
        rel_n       = 2'd0;
        rel_ch      = 8'd0;
        byte_en     = 1'b0;
        byte_role   = ROLE_BODY;
        rec_en      = 1'b0;
        rec_type    = LT_TEXT;
        hid         = 1'b0;
        lfu         = 1'b0;

        if (has_char)
        begin
            unique case (phase_next)
                PH_STAR:
                begin
                    if (char_value == CH_SPACE)
                    begin
                        pend_next  = 2'd0;
                        kind_next  = LT_ITEM;
                        phase_next = PH_SKIPWS;
                    end
                    else
                        go_body = 1'b1;
                end
                PH_EQ:
                begin
                    if (char_value == CH_GT)
                    begin
                        pend_next  = 2'd0;
                        kind_next  = LT_TEXT;
                        phase_next = PH_LINKWS;
                    end
                    else
                        go_body = 1'b1;
                end
                PH_TICK:
                begin
                    if (char_value != CH_TICK)
                        go_body = 1'b1;
                    else if (pend_next < 2'd2)
                        pend_next = pend_next + 2'd1;
                    else
                    begin
                        pend_next = 2'd0;
                        if (in_pre_next)
                        begin
                            kind_next  = LT_PRE_END;
                            phase_next = PH_DROP;
                        end
                        else
                        begin
                            kind_next  = LT_PRE_START;
                            phase_next = PH_SKIPWS;
                        end
                    end
                end
                PH_HASH:
                begin
                    if (char_value == CH_HASH && kind_next < LT_H3)
                    begin
                        kind_next = kind_next + 4'd1;
                        if (kind_next == LT_H3)
                            phase_next = PH_SKIPWS;
                    end
                    else if (!ws)
                    begin
                        phase_next = PH_BODY;
                        byte_en    = 1'b1;
                    end
                    else
                        phase_next = PH_SKIPWS;
                end
                PH_SKIPWS:
                begin
                    if (!ws)
                    begin
                        phase_next = PH_BODY;
                        byte_en    = 1'b1;
                    end
                end
                PH_BODY:
                    byte_en = 1'b1;
                PH_LINKWS:
                begin
                    if (!ws)
                    begin
                        kind_next  = LT_LINK;
                        phase_next = PH_URL;
                        byte_en    = 1'b1;
                        byte_role  = ROLE_URL;
                    end
                end
                PH_URL:
                begin
                    if (ws)
                        phase_next = PH_GAP;
                    else
                    begin
                        byte_en   = 1'b1;
                        byte_role = ROLE_URL;
                    end
                end
                PH_GAP:
                begin
                    if (!ws)
                    begin
                        label_next = 1'b1;
                        phase_next = PH_LABEL;
                        byte_en    = 1'b1;
                        byte_role  = ROLE_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    byte_en   = 1'b1;
                    byte_role = ROLE_LABEL;
                end
                PH_DROP:
                    ;
                default:
                begin
                    // start of line, and any stray code
                    pend_next = 2'd0;
                    if (char_value == CH_TICK)
                    begin
                        pend_next  = 2'd1;
                        phase_next = PH_TICK;
                    end
                    else if (in_pre_next)
                        go_body = 1'b1;
                    else if (char_value == CH_STAR)
                    begin
                        pend_next  = 2'd1;
                        phase_next = PH_STAR;
                    end
                    else if (char_value == CH_EQ)
                    begin
                        pend_next  = 2'd1;
                        phase_next = PH_EQ;
                    end
                    else if (char_value == CH_GT)
                    begin
                        kind_next  = LT_QUOTE;
                        phase_next = PH_SKIPWS;
                    end
                    else if (char_value == CH_HASH)
                    begin
                        kind_next  = LT_H1;
                        phase_next = PH_HASH;
                    end
                    else
                        go_body = 1'b1;
                end
            endcase

            // undecided prefix turned out to be content: release held bytes
            if (go_body)
            begin
                rel_n      = pend_next;
                rel_ch     = marker(phase_next);
                pend_next  = 2'd0;
                kind_next  = in_pre_next ? LT_PRE_CONTENT : LT_TEXT;
                phase_next = PH_BODY;
                byte_en    = 1'b1;
                byte_role  = ROLE_BODY;
            end
        end

        if (last_in_line)
        begin
            if (phase_next == PH_STAR || phase_next == PH_EQ || phase_next == PH_TICK)
            begin
                rel_n     = pend_next;
                rel_ch    = marker(phase_next);
                kind_next = in_pre_next ? LT_PRE_CONTENT : LT_TEXT;
            end
            else if (phase_next == PH_START)
                kind_next = in_pre_next ? LT_PRE_CONTENT : LT_TEXT;

            if (kind_next == LT_PRE_START || kind_next == LT_PRE_END)
                hid = cfg.hide_pre_fence || (kind_next == LT_PRE_END && cfg.hide_pre_closing);
            else if (kind_next == LT_PRE_CONTENT)
                hid = cfg.hide_pre_content;
            if (cfg.styling_off)
                hid = 1'b0;

            if (kind_next == LT_PRE_START)
                in_pre_next = 1'b1;
            else if (kind_next == LT_PRE_END)
                in_pre_next = 1'b0;

            lfu        = (kind_next == LT_LINK) && !label_next;
            rec_en     = 1'b1;
            rec_type   = kind_next;
            phase_next = PH_START;
            pend_next  = 2'd0;
            kind_next  = LT_TEXT;
            label_next = 1'b0;
        end
    end

    assign pkt.mask           = {rec_en, byte_en, rel_n[1], rel_n[1] | rel_n[0]};
    assign pkt.rel_char       = rel_ch;
    assign pkt.ch             = char_value;
    assign pkt.role           = byte_role;
    assign pkt.line_class     = rec_type;
    assign pkt.hidden         = hid;
    assign pkt.label_from_url = lfu;
    assign pkt_valid          = |pkt.mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            in_pre_reg <= 1'b0;
            pend_reg   <= 2'd0;
            kind_reg   <= LT_TEXT;
            label_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            in_pre_reg <= in_pre_next;
            pend_reg   <= pend_next;
            kind_reg   <= kind_next;
            label_reg  <= label_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/glc_queue.sv */
// glc_queue: short word queue between the classifier and the result expander.
// Depends on glc_pkg for the word type.
`default_nettype none

module glc_queue
    import glc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire pkt_t wr_data,
    input  wire logic rd_en,
    output pkt_t      rd_data,
    output logic      empty,
    output logic      full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    pkt_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign rd_data = mem_reg[rd_ptr_reg];
    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == FULL_CNT);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* rtl/glc_back.sv */
// glc_back: expands one queue word into its results, one result per cycle
// while pop is high, through a registered output stage. Depends on glc_pkg.
`default_nettype none

module glc_back
    import glc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire pkt_t head,
    input  wire logic q_empty,
    output logic      q_pop,
    input  wire logic pop,
    output logic      out_valid,
    output res_t      res
);

    logic [3:0] done_reg, done_next;
    logic       valid_reg, valid_next;
    res_t       res_reg, res_next;

    logic [3:0] rem;
    logic [3:0] sel;
    logic       last;
    logic       load;

    assign rem  = head.mask & ~done_reg;
    assign sel  = rem & (~rem + 4'd1);   // lowest pending result
    assign last = ((rem & ~sel) == 4'd0);
    assign load = !q_empty && (!valid_reg || pop);

    always_comb
    begin
        res_next   = res_reg;
        valid_next = valid_reg;
        done_next  = done_reg;
        q_pop      = 1'b0;
        if (valid_reg && pop)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next           = 1'b1;
            res_next             = '0;
            res_next.last_result = last;
            if (sel[3])
            begin
                res_next.line_record    = 1'b1;
                res_next.line_class     = head.line_class;
                res_next.hidden         = head.hidden;
                res_next.label_from_url = head.label_from_url;
            end
            else if (sel[2])
            begin
                res_next.out_char     = head.ch;
                res_next.has_out_char = 1'b1;
                res_next.char_role    = head.role;
            end
            else
            begin
                res_next.out_char     = head.rel_char;
                res_next.has_out_char = 1'b1;
                res_next.char_role    = ROLE_BODY;
            end
            done_next = last ? 4'd0 : (done_reg | sel);
            q_pop     = last;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* rtl/gemtext_line_classifier.sv */
// gemtext_line_classifier: top level; configuration registers on an APB-style
// port, classifier front, word queue and result expander. Depends on glc_pkg,
// glc_front, glc_queue and glc_back.
//
//  port group   direction  handshake            payload
//  input        in         push / full          char_value, has_char, last_in_line
//  results      out        empty / pop          out_char .. last_result
//  config       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// The front takes one item a cycle whenever the queue has room; it classifies
// the byte in the same cycle and queues one word per item that yields results.
// The back hands out one result a cycle from a registered output stage while
// the receiver pops, so an item giving up to 4 results holds the back until
// all are out; the queue of QUEUE_DEPTH words absorbs this. Reset clears all
// control state at once; no clearing pass.
`default_nettype none

module gemtext_line_classifier
    import glc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input queue side
    input  wire logic [7:0]  char_value,
    input  wire logic        has_char,
    input  wire logic        last_in_line,
    input  wire logic        push,
    output logic             full,
    // result queue side
    output logic [7:0]       out_char,
    output logic             has_out_char,
    output logic [1:0]       char_role,
    output logic             line_record,
    output logic [3:0]       line_class,
    output logic             hidden,
    output logic             label_from_url,
    output logic             last_result,
    output logic             empty,
    input  wire logic        pop,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t cfg_reg, cfg_next;
    logic cfg_wr;
    logic rd_bit;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        rd_bit   = 1'b0;
        unique case (paddr[3:2])
            REG_HIDE_PRE_FENCE:
            begin
                rd_bit = cfg_reg.hide_pre_fence;
                if (cfg_wr)
                    cfg_next.hide_pre_fence = pwdata[0];
            end
            REG_HIDE_PRE_CLOSING:
            begin
                rd_bit = cfg_reg.hide_pre_closing;
                if (cfg_wr)
                    cfg_next.hide_pre_closing = pwdata[0];
            end
            REG_HIDE_PRE_CONTENT:
            begin
                rd_bit = cfg_reg.hide_pre_content;
                if (cfg_wr)
                    cfg_next.hide_pre_content = pwdata[0];
            end
            REG_STYLING_OFF:
            begin
                rd_bit = cfg_reg.styling_off;
                if (cfg_wr)
                    cfg_next.styling_off = pwdata[0];
            end
            default:
                rd_bit = 1'b0;
        endcase
    end

    assign prdata = {31'd0, rd_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    pkt_t fr_pkt;
    logic fr_valid;
    logic take;
    pkt_t q_head;
    logic q_empty;
    logic q_full;
    logic q_pop;
    logic out_valid;
    res_t res;

    assign full = q_full;
    assign take = push && !q_full;

    glc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_value   (char_value),
        .has_char     (has_char),
        .last_in_line (last_in_line),
        .take         (take),
        .cfg          (cfg_reg),
        .pkt          (fr_pkt),
        .pkt_valid    (fr_valid)
    );

    glc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take && fr_valid),
        .wr_data (fr_pkt),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty),
        .full    (q_full)
    );

    glc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .pop       (pop),
        .out_valid (out_valid),
        .res       (res)
    );

    assign empty          = !out_valid;
    assign out_char       = res.out_char;
    assign has_out_char   = res.has_out_char;
    assign char_role      = res.char_role;
    assign line_record    = res.line_record;
    assign line_class     = res.line_class;
    assign hidden         = res.hidden;
    assign label_from_url = res.label_from_url;
    assign last_result    = res.last_result;

    // a line record closes the item that caused it
    a_rec_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && line_record) |-> (last_result && !has_out_char))
        else $error("line record not last or carries a byte");

    // label_from_url only on link records
    a_lfu_link: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && label_from_url) |-> (line_record && line_class == LT_LINK))
        else $error("label_from_url on a non-link result");

    // byte results carry a legal role and no line type
    a_byte_role: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && has_out_char) |->
            ((char_role == ROLE_BODY || char_role == ROLE_URL || char_role == ROLE_LABEL)
             && line_class == LT_TEXT))
        else $error("bad byte result");

    // the queue is never popped while empty
    a_pop_safe: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// tb_top: self-checking bench for gemtext_line_classifier.
// Feeds lines byte by byte, mirrors the classifier in a behavioural model and
// checks every result word in order. Depends on glc_pkg and the RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import glc_pkg::*;

    typedef enum logic [3:0] {
        S_START, S_STAR, S_EQ, S_TICK, S_HASH, S_SKIPWS,
        S_BODY, S_LINKWS, S_URL, S_GAP, S_LABEL, S_DROP
    } scan_t;

    typedef struct {
        logic [7:0] c;
        logic       has;
        logic       last;
        logic       typed;
        logic [3:0] want_type;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  char_value = '0;
    logic        has_char = 1'b0;
    logic        last_in_line = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  out_char;
    logic        has_out_char;
    logic [1:0]  char_role;
    logic        line_record;
    logic [3:0]  line_class;
    logic        hidden;
    logic        label_from_url;
    logic        last_result;
    logic        empty;
    logic        pop = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // travels with each item: record typed in by hand instead of the model's
    logic        item_typed = 1'b0;
    logic [3:0]  item_want = LT_TEXT;

    // model state
    cfg_t        cfg_copy = '0;
    scan_t       scan = S_START;
    logic        in_pre = 1'b0;
    logic [7:0]  held_bytes [2];
    int unsigned held_count = 0;
    logic [3:0]  kind = LT_TEXT;
    logic        label_seen = 1'b0;

    res_t        step_res [$];
    res_t        classified_q [$];
    logic [7:0]  line_q [$];
    stim_row_t   directed [$];
    int          fails = 0;
    int          items_sent = 0;
    bit          quiet = 1'b0;

    gemtext_line_classifier i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_value     (char_value),
        .has_char       (has_char),
        .last_in_line   (last_in_line),
        .push           (push),
        .full           (full),
        .out_char       (out_char),
        .has_out_char   (has_out_char),
        .char_role      (char_role),
        .line_record    (line_record),
        .line_class     (line_class),
        .hidden         (hidden),
        .label_from_url (label_from_url),
        .last_result    (last_result),
        .empty          (empty),
        .pop            (pop),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 clk = ~clk;

    initial
    begin
        #200_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void emit_byte(logic [7:0] c, logic [1:0] role);
        res_t r;
        r = '0;
        r.out_char = c;
        r.has_out_char = 1'b1;
        r.char_role = role;
        step_res.push_back(r);
    endfunction

    function automatic void release_held();
        for (int i = 0; i < held_count && i < 2; i++)
            emit_byte(held_bytes[i], ROLE_BODY);
        held_count = 0;
    endfunction

    function automatic void hold_byte(logic [7:0] c);
        if (held_count < 2)
        begin
            held_bytes[held_count] = c;
            held_count++;
        end
    endfunction

    function automatic void to_body(logic [7:0] c);
        release_held();
        kind = in_pre ? LT_PRE_CONTENT : LT_TEXT;
        scan = S_BODY;
        emit_byte(c, ROLE_BODY);
    endfunction

    function automatic void take_byte(logic [7:0] c);
        case (scan)
            S_STAR:
                // only a real space makes a list item
                if (c == CH_SPACE)
                begin
                    held_count = 0;
                    kind = LT_ITEM;
                    scan = S_SKIPWS;
                end
                else
                    to_body(c);
            S_EQ:
                if (c == CH_GT)
                begin
                    held_count = 0;
                    kind = LT_TEXT;
                    scan = S_LINKWS;
                end
                else
                    to_body(c);
            S_TICK:
                if (c != CH_TICK)
                    to_body(c);
                else if (held_count < 2)
                    hold_byte(c);
                else
                begin
                    held_count = 0;
                    if (in_pre)
                    begin
                        kind = LT_PRE_END;
                        scan = S_DROP;
                    end
                    else
                    begin
                        kind = LT_PRE_START;
                        scan = S_SKIPWS;
                    end
                end
            S_HASH:
                if (c == CH_HASH && kind < LT_H3)
                begin
                    kind = kind + 4'd1;
                    if (kind == LT_H3)
                        scan = S_SKIPWS;
                end
                else if (!is_blank(c))
                begin
                    scan = S_BODY;
                    emit_byte(c, ROLE_BODY);
                end
                else
                    scan = S_SKIPWS;
            S_SKIPWS:
                if (!is_blank(c))
                begin
                    scan = S_BODY;
                    emit_byte(c, ROLE_BODY);
                end
            S_BODY:
                emit_byte(c, ROLE_BODY);
            S_LINKWS:
                if (!is_blank(c))
                begin
                    kind = LT_LINK;
                    scan = S_URL;
                    emit_byte(c, ROLE_URL);
                end
            S_URL:
                if (is_blank(c))
                    scan = S_GAP;
                else
                    emit_byte(c, ROLE_URL);
            S_GAP:
                if (!is_blank(c))
                begin
                    label_seen = 1'b1;
                    scan = S_LABEL;
                    emit_byte(c, ROLE_LABEL);
                end
            S_LABEL:
                emit_byte(c, ROLE_LABEL);
            S_DROP:
                ;
            default:
            begin
                held_count = 0;
                if (c == CH_TICK)
                begin
                    hold_byte(c);
                    scan = S_TICK;
                end
                else if (in_pre)
                    to_body(c);
                else if (c == CH_STAR)
                begin
                    hold_byte(c);
                    scan = S_STAR;
                end
                else if (c == CH_EQ)
                begin
                    hold_byte(c);
                    scan = S_EQ;
                end
                else if (c == CH_GT)
                begin
                    kind = LT_QUOTE;
                    scan = S_SKIPWS;
                end
                else if (c == CH_HASH)
                begin
                    kind = LT_H1;
                    scan = S_HASH;
                end
                else
                    to_body(c);
            end
        endcase
    endfunction

    function automatic void end_line();
        res_t r;
        logic hid;
        hid = 1'b0;
        // undecided prefix at line end: it was plain content after all
        if (scan == S_STAR || scan == S_EQ || scan == S_TICK)
        begin
            release_held();
            kind = in_pre ? LT_PRE_CONTENT : LT_TEXT;
        end
        else if (scan == S_START)
            kind = in_pre ? LT_PRE_CONTENT : LT_TEXT;
        if (kind == LT_PRE_START || kind == LT_PRE_END)
        begin
            if (cfg_copy.hide_pre_fence)
                hid = 1'b1;
            if (kind == LT_PRE_END && cfg_copy.hide_pre_closing)
                hid = 1'b1;
        end
        else if (kind == LT_PRE_CONTENT && cfg_copy.hide_pre_content)
            hid = 1'b1;
        if (cfg_copy.styling_off)
            hid = 1'b0;
        if (kind == LT_PRE_START)
            in_pre = 1'b1;
        else if (kind == LT_PRE_END)
            in_pre = 1'b0;
        r = '0;
        r.line_record = 1'b1;
        r.line_class = kind;
        r.hidden = hid;
        r.label_from_url = (kind == LT_LINK) && !label_seen;
        step_res.push_back(r);
        scan = S_START;
        held_count = 0;
        kind = LT_TEXT;
        label_seen = 1'b0;
    endfunction

    function automatic void classify_item(logic [7:0] c, logic h, logic l);
        step_res.delete();
        if (h)
            take_byte(c);
        if (l)
            end_line();
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last_result = 1'b1;
    endfunction

    // -------------------------------------------------------------- checking

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
                case (paddr[3:2])
                    REG_HIDE_PRE_FENCE:   cfg_copy.hide_pre_fence   = pwdata[0];
                    REG_HIDE_PRE_CLOSING: cfg_copy.hide_pre_closing = pwdata[0];
                    REG_HIDE_PRE_CONTENT: cfg_copy.hide_pre_content = pwdata[0];
                    REG_STYLING_OFF:      cfg_copy.styling_off      = pwdata[0];
                    default: ;
                endcase
            if (push && !full)
            begin
                classify_item(char_value, has_char, last_in_line);
                if (item_typed)
                begin
                    want = '0;
                    want.line_record = 1'b1;
                    want.line_class = item_want;
                    want.last_result = 1'b1;
                    classified_q.push_back(want);
                end
                else
                    foreach (step_res[i])
                        classified_q.push_back(step_res[i]);
            end
            if (pop && !empty)
            begin
                if (classified_q.size() == 0)
                begin
                    $error("unexpected word: out_char %0h line_record %0b line_class %0d",
                           out_char, line_record, line_class);
                    fails++;
                end
                else
                begin
                    want = classified_q.pop_front();
                    check_field("out_char", want.out_char, out_char);
                    check_field("has_out_char", want.has_out_char, has_out_char);
                    check_field("char_role", want.char_role, char_role);
                    check_field("line_record", want.line_record, line_record);
                    check_field("line_class", want.line_class, line_class);
                    check_field("hidden", want.hidden, hidden);
                    check_field("label_from_url", want.label_from_url, label_from_url);
                    check_field("last_result", want.last_result, last_result);
                end
            end
        end
    end

    // ----------------------------------------------------------------- drive

    task automatic send_item(logic [7:0] c, logic h, logic l, logic typed, logic [3:0] want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_value   <= c;
        has_char     <= h;
        last_in_line <= l;
        item_typed   <= typed;
        item_want    <= want;
        push         <= 1'b1;
        do
            @(posedge clk);
        while (!(push && !full));
    endtask

    task automatic apb_write(logic [1:0] idx, logic val);
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, val};
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for the block to drain, plus a margin for items that give no word
    task automatic settle();
        while (classified_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(9 + r);
    endfunction

    function automatic void add_ws(int n);
        repeat (n) line_q.push_back(blank_byte());
    endfunction

    function automatic void add_word(int n);
        repeat (n) line_q.push_back(8'($urandom_range(33, 126)));
    endfunction

    function automatic void add_text(int n);
        repeat (n) line_q.push_back(8'($urandom_range(32, 126)));
    endfunction

    function automatic void build_line();
        int n;
        line_q.delete();
        case ($urandom_range(0, 11))
            0: add_text($urandom_range(0, 6));
            1:
            begin
                n = $urandom_range(1, 4);
                repeat (n) line_q.push_back(CH_HASH);
                add_ws($urandom_range(0, 2));
                add_text($urandom_range(0, 5));
            end
            2:
            begin
                line_q.push_back(CH_STAR);
                line_q.push_back(CH_SPACE);
                add_ws($urandom_range(0, 1));
                add_text($urandom_range(0, 5));
            end
            3:
            begin
                line_q.push_back(CH_STAR);
                if ($urandom_range(0, 1))
                    line_q.push_back(8'($urandom_range(0, 255)));
            end
            4:
            begin
                line_q.push_back(CH_GT);
                add_ws($urandom_range(0, 2));
                add_text($urandom_range(0, 5));
            end
            5:
            begin
                line_q.push_back(CH_EQ);
                line_q.push_back(CH_GT);
                add_ws($urandom_range(0, 2));
                add_word($urandom_range(1, 5));
                if ($urandom_range(0, 1))
                begin
                    add_ws($urandom_range(1, 2));
                    add_text($urandom_range(0, 5));
                end
            end
            6:
            begin
                line_q.push_back(CH_EQ);
                line_q.push_back(CH_GT);
                add_ws($urandom_range(0, 3));
            end
            7:
            begin
                repeat (3) line_q.push_back(CH_TICK);
                add_text($urandom_range(0, 4));
            end
            8:
            begin
                n = $urandom_range(1, 2);
                repeat (n) line_q.push_back(CH_TICK);
                add_text($urandom_range(0, 3));
            end
            9:
            begin
                line_q.push_back(CH_EQ);
                add_text($urandom_range(0, 3));
            end
            10:
            begin
                n = $urandom_range(1, 6);
                repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                add_ws($urandom_range(1, 2));
                add_text($urandom_range(0, 4));
            end
        endcase
    endfunction

    // line end rides on the last byte, or comes as an item with no byte
    task automatic send_line();
        bit end_on_byte;
        end_on_byte = (line_q.size() > 0) && ($urandom_range(0, 3) != 0);
        foreach (line_q[i])
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, LT_TEXT);
                items_sent++;
            end
            send_item(line_q[i], 1'b1, end_on_byte && (i == line_q.size() - 1),
                      1'b0, LT_TEXT);
            items_sent++;
        end
        if (!end_on_byte)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, LT_TEXT);
            items_sent++;
        end
    endtask

    function automatic stim_row_t row(logic [7:0] c, logic h, logic l);
        stim_row_t r;
        r.c = c;
        r.has = h;
        r.last = l;
        r.typed = 1'b0;
        r.want_type = LT_TEXT;
        return r;
    endfunction

    function automatic stim_row_t rec_row(logic [7:0] c, logic h, logic l, logic [3:0] t);
        stim_row_t r;
        r = row(c, h, l);
        r.typed = 1'b1;
        r.want_type = t;
        return r;
    endfunction

    // receiver: random stalls, with long hold-offs so the block backs up
    initial
    begin
        int gap;
        int n_popped;
        n_popped = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (n_popped == 40 || n_popped == 300)
                gap = 150;
            else
                gap = quiet ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (!(pop && !empty));
            n_popped++;
        end
    end

    initial
    begin
        cfg_t setting;
        int waited;

        // empty line, ignored item, deep heading, lone star, bare arrow
        directed.push_back(rec_row(8'h00, 1'b0, 1'b1, LT_TEXT));
        directed.push_back(row(8'hFF, 1'b0, 1'b0));
        repeat (3) directed.push_back(row(CH_HASH, 1'b1, 1'b0));
        directed.push_back(row(CH_HASH, 1'b1, 1'b1));
        directed.push_back(row(CH_STAR, 1'b1, 1'b1));
        directed.push_back(row(CH_EQ, 1'b1, 1'b0));
        directed.push_back(row(CH_GT, 1'b1, 1'b0));
        directed.push_back(rec_row(CH_SPACE, 1'b1, 1'b1, LT_TEXT));
        // fence, content, fence with trailing junk dropped
        repeat (3) directed.push_back(row(CH_TICK, 1'b1, 1'b0));
        directed.push_back(rec_row(8'h00, 1'b0, 1'b1, LT_PRE_START));
        directed.push_back(row(8'hFF, 1'b1, 1'b1));
        repeat (3) directed.push_back(row(CH_TICK, 1'b1, 1'b0));
        directed.push_back(rec_row("z", 1'b1, 1'b1, LT_PRE_END));
        // link with label, quote, list item
        directed.push_back(row(CH_EQ, 1'b1, 1'b0));
        directed.push_back(row(CH_GT, 1'b1, 1'b0));
        directed.push_back(row("u", 1'b1, 1'b0));
        directed.push_back(row(CH_SPACE, 1'b1, 1'b0));
        directed.push_back(row("L", 1'b1, 1'b1));
        directed.push_back(row(CH_GT, 1'b1, 1'b0));
        directed.push_back(row("q", 1'b1, 1'b1));
        directed.push_back(row(CH_STAR, 1'b1, 1'b0));
        directed.push_back(row(CH_SPACE, 1'b1, 1'b0));
        directed.push_back(row(8'h00, 1'b1, 1'b1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i].c, directed[i].has, directed[i].last,
                      directed[i].typed, directed[i].want_type);
        push <= 1'b0;

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0: setting = 4'b1111;
                1: setting = 4'b1110;
                2: setting = 4'b0000;
                3: setting = 4'b0100;
                4: setting = 4'b0010;
                default: setting = 4'($urandom_range(0, 15));
            endcase
            apb_write(REG_HIDE_PRE_FENCE, setting.hide_pre_fence);
            apb_write(REG_HIDE_PRE_CLOSING, setting.hide_pre_closing);
            apb_write(REG_HIDE_PRE_CONTENT, setting.hide_pre_content);
            apb_write(REG_STYLING_OFF, setting.styling_off);
            quiet = (p == 2);
            items_sent = 0;
            while (items_sent < 24)
            begin
                build_line();
                send_line();
            end
            push <= 1'b0;
        end
        quiet = 1'b0;

        waited = 0;
        while (classified_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (classified_q.size() != 0)
        begin
            $error("%0d words never arrived", classified_q.size());
            fails++;
        end
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
